// File: rtl/assert_macros.svh
// Assertion macros shared by the interpolator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LMI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LMI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lmi_pkg.sv
// Types and constants of the linear move interpolator.
package lmi_pkg;

    localparam int IDX_W   = 6;     // point index width
    localparam int PER_W   = 20;    // step period register width
    localparam int MAG_W   = 33;    // per-axis distance magnitude
    localparam int MUL_AW  = 34;    // multiplicand width
    localparam int MUL_BW  = 33;    // serial multiplier operand width
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int SUM_W   = 66;    // sum of squares
    localparam int ROOT_W  = 34;    // length
    localparam int DVD_W   = 66;    // dividend
    localparam int DVS_W   = 52;    // divisor
    localparam int QUO_W   = 34;    // kept quotient bits
    localparam int DEN_W   = 52;
    localparam int NUM_W   = 65;

    localparam logic [PER_W-1:0] PERIOD_RST = 20'd1000;
    localparam logic [PER_W-1:0] MICRO      = 20'd1000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQRT,
        S_DEN,
        S_NUM,
        S_DIVN,
        S_VMUL,
        S_VDIV,
        S_PDIV,
        S_EMIT,
        S_DEGEN
    } t_state;

endpackage

// File: rtl/lmi_ser_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module lmi_ser_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lmi_pkg::MUL_AW-1:0] i_a,
    input  logic [lmi_pkg::MUL_BW-1:0] i_b,
    output logic                      o_done,
    output logic [lmi_pkg::MUL_PW-1:0] o_prod
);
    import lmi_pkg::*;

    localparam int CW = $clog2(MUL_BW + 1);

    logic [MUL_AW-1:0] r_a;
    logic [MUL_PW-1:0] r_p;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [MUL_AW:0]   add;

    // add multiplicand into the high half when the current bit is set
    assign add = {1'b0, r_p[MUL_PW-1:MUL_BW]} + (r_p[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MUL_BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{MUL_AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {add, r_p[MUL_BW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// File: rtl/lmi_ser_sqrt.sv
// Restoring integer square root, two radicand bits per cycle.
module lmi_ser_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lmi_pkg::SUM_W-1:0]  i_rad,
    output logic                       o_done,
    output logic [lmi_pkg::ROOT_W-1:0] o_root
);
    import lmi_pkg::*;

    localparam int SRC_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int CW    = $clog2(ROOT_W + 1);

    logic [SRC_W-1:0]  r_src;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    assign rem_sh = {r_rem, r_src[SRC_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one root bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src  <= {{(SRC_W-SUM_W){1'b0}}, i_rad};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_src  <= {r_src[SRC_W-3:0], 2'b00};
            r_rem  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/lmi_ser_div.sv
// Restoring long divider, one quotient bit per cycle, overflow kept sticky.
`include "assert_macros.svh"
module lmi_ser_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lmi_pkg::DVD_W-1:0] i_dvd,
    input  logic [lmi_pkg::DVS_W-1:0] i_dvs,
    output logic                      o_done,
    output logic [lmi_pkg::QUO_W-1:0] o_quo,
    output logic                      o_ovf,
    output logic [lmi_pkg::DVS_W-1:0] o_rem
);
    import lmi_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= fits ? DVS_W'(rem_sh - {1'b0, r_dvs}) : DVS_W'(rem_sh);
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_ovf <= r_ovf | r_quo[QUO_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;
    assign o_rem  = r_rem;

    `LMI_ASSERT_IMP(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")
    `LMI_ASSERT_NXT(a_div_start_runs, i_clk, i_rst_n, i_start, r_busy, "divider did not start")

endmodule

// File: rtl/linear_move_interpolator.sv
// Top level: 3-axis linear move interpolator with bit-serial arithmetic.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+--------------------------
//  move in  | i_start_*, i_target_*, i_feed_rate   | start & !busy
//  points   | o_pos_*, o_vel_*, o_point_index, ... | o_strobe, one cycle each
//  config   | i_cfg_wdata                          | i_cfg_we, no wait
//
// A normal move runs the serial units before its points: the divider seven
// times (step count, and velocity and step size per axis; six when a zero
// divisor caps the step count), the multiplier eight times, the root once.
// A degenerate move (zero feed, length or step count) gives one point at the
// target. The n + 1 points of a normal move come out on consecutive cycles;
// busy stays high until the last one is registered. Reset clears control
// state; the step period returns to 1000. The receiver cannot stall them.
`include "assert_macros.svh"
module linear_move_interpolator #(
    parameter int MAX_STEPS = 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [31:0]               i_start_x,
    input  logic [31:0]               i_start_y,
    input  logic [31:0]               i_start_z,
    input  logic [31:0]               i_target_x,
    input  logic [31:0]               i_target_y,
    input  logic [31:0]               i_target_z,
    input  logic [31:0]               i_feed_rate,
    input  logic                      i_cfg_we,
    input  logic [lmi_pkg::PER_W-1:0] i_cfg_wdata,
    output logic                      o_strobe,
    output logic [31:0]               o_pos_x,
    output logic [31:0]               o_pos_y,
    output logic [31:0]               o_pos_z,
    output logic [31:0]               o_vel_x,
    output logic [31:0]               o_vel_y,
    output logic [31:0]               o_vel_z,
    output logic [lmi_pkg::IDX_W-1:0] o_point_index,
    output logic                      o_steps_capped,
    output logic                      o_last_point
);
    import lmi_pkg::*;

    localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_STEPS);

    // control and data registers
    t_state                      r_state, n_state;
    logic                        r_kick, n_kick;
    logic [1:0]                  r_ax, n_ax;
    logic [PER_W-1:0]            r_period;
    logic [2:0][31:0]            r_s, r_t;
    logic [2:0][MAG_W-1:0]       r_mag;
    logic [2:0]                  r_neg;
    logic [31:0]                 r_feed;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [ROOT_W-1:0]           r_len, n_len;
    logic [DEN_W-1:0]            r_den, n_den;
    logic [NUM_W-1:0]            r_num, n_num;
    logic [IDX_W-1:0]            r_n, n_n;
    logic                        r_cap, n_cap;
    logic [2:0][31:0]            r_vel, n_vel;
    logic [2:0][MAG_W-1:0]       r_qstep, n_qstep, r_qacc, n_qacc;
    logic [2:0][IDX_W-1:0]       r_rstep, n_rstep, r_racc, n_racc;
    logic [IDX_W-1:0]            r_k, n_k;

    // output registers
    logic                        r_out_valid, n_out_valid;
    logic [2:0][31:0]            r_out_pos, n_out_pos, r_out_vel, n_out_vel;
    logic [IDX_W-1:0]            r_out_idx, n_out_idx;
    logic                        r_out_cap, n_out_cap;
    logic                        r_out_last, n_out_last;

    // arithmetic unit connections
    logic                        mul_start, mul_done;
    logic [MUL_AW-1:0]           mul_a;
    logic [MUL_BW-1:0]           mul_b;
    logic [MUL_PW-1:0]           mul_prod;
    logic                        sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]           sqrt_root;
    logic                        div_start, div_done, div_ovf;
    logic [DVD_W-1:0]            div_dvd;
    logic [DVS_W-1:0]            div_dvs;
    logic [QUO_W-1:0]            div_quo;
    logic [DVS_W-1:0]            div_rem;

    logic                        accept;
    logic [2:0][31:0]            in_s, in_t;
    logic [2:0][MAG_W-1:0]       in_d;
    logic [31:0]                 vel_sat;
    logic [2:0][31:0]            pos_now;
    logic [2:0][IDX_W:0]         rsum;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign in_s   = {i_start_z, i_start_y, i_start_x};
    assign in_t   = {i_target_z, i_target_y, i_target_x};

    lmi_ser_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    lmi_ser_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    lmi_ser_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf),
        .o_rem   (div_rem)
    );

    // per-axis signed distance, registered with its magnitude on accept
    always_comb begin
        logic [MAG_W-1:0] dd;
        for (int a = 0; a < 3; a++) begin
            dd = {in_t[a][31], in_t[a]} - {in_s[a][31], in_s[a]};
            in_d[a] = dd;
        end
    end

    // velocity saturation from the divider quotient
    always_comb begin
        if (r_neg[r_ax]) begin
            if (div_ovf || div_quo > QUO_W'(33'h080000000)) begin
                vel_sat = 32'h80000000;
            end else begin
                vel_sat = 32'(-div_quo);
            end
        end else begin
            if (div_ovf || div_quo > QUO_W'(33'h07FFFFFFF)) begin
                vel_sat = 32'h7FFFFFFF;
            end else begin
                vel_sat = div_quo[31:0];
            end
        end
    end

    // current point positions and remainder steps
    always_comb begin
        logic [MAG_W:0] off;
        for (int a = 0; a < 3; a++) begin
            off        = r_neg[a] ? -{1'b0, r_qacc[a]} : {1'b0, r_qacc[a]};
            pos_now[a] = 32'({{2{r_s[a][31]}}, r_s[a]} + off);
            rsum[a]    = {1'b0, r_racc[a]} + {1'b0, r_rstep[a]};
        end
    end

    // sequencer: next state, unit operands and output registers
    always_comb begin
        n_state     = r_state;
        n_kick      = 1'b0;
        n_ax        = r_ax;
        n_sum       = r_sum;
        n_len       = r_len;
        n_den       = r_den;
        n_num       = r_num;
        n_n         = r_n;
        n_cap       = r_cap;
        n_vel       = r_vel;
        n_qstep     = r_qstep;
        n_rstep     = r_rstep;
        n_qacc      = r_qacc;
        n_racc      = r_racc;
        n_k         = r_k;
        n_out_valid = 1'b0;
        n_out_pos   = r_out_pos;
        n_out_vel   = r_out_vel;
        n_out_idx   = r_out_idx;
        n_out_cap   = r_out_cap;
        n_out_last  = r_out_last;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        div_dvd     = '0;
        div_dvs     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SQ;
                    n_kick  = 1'b1;
                    n_ax    = '0;
                    n_sum   = '0;
                    n_cap   = 1'b0;
                end
            end
            S_SQ: begin
                mul_start = r_kick;
                mul_a     = MUL_AW'(r_mag[r_ax]);
                mul_b     = r_mag[r_ax];
                if (mul_done) begin
                    n_sum  = r_sum + mul_prod[SUM_W-1:0];
                    n_kick = 1'b1;
                    if (r_ax == 2'd2) begin
                        n_state = S_SQRT;
                    end else begin
                        n_ax = r_ax + 1'b1;
                    end
                end
            end
            S_SQRT: begin
                sqrt_start = r_kick;
                if (sqrt_done) begin
                    n_len = sqrt_root;
                    if (r_feed == '0 || sqrt_root == '0) begin
                        n_state = S_DEGEN;
                    end else begin
                        n_state = S_DEN;
                        n_kick  = 1'b1;
                    end
                end
            end
            S_DEN: begin
                mul_start = r_kick;
                mul_a     = MUL_AW'(r_feed);
                mul_b     = MUL_BW'(r_period);
                if (mul_done) begin
                    n_den   = mul_prod[DEN_W-1:0];
                    n_state = S_NUM;
                    n_kick  = 1'b1;
                end
            end
            S_NUM: begin
                mul_start = r_kick;
                mul_a     = r_len;
                mul_b     = MUL_BW'(MICRO);
                if (mul_done) begin
                    n_num  = mul_prod[NUM_W-1:0];
                    n_kick = 1'b1;
                    n_ax   = '0;
                    if (r_den == '0) begin
                        n_n     = MAX_N;
                        n_cap   = 1'b1;
                        n_state = S_VMUL;
                    end else begin
                        n_state = S_DIVN;
                    end
                end
            end
            S_DIVN: begin
                div_start = r_kick;
                div_dvd   = DVD_W'(r_num);
                div_dvs   = DVS_W'(r_den);
                if (div_done) begin
                    if (div_ovf || div_quo > QUO_W'(MAX_N)) begin
                        n_n     = MAX_N;
                        n_cap   = 1'b1;
                        n_state = S_VMUL;
                        n_kick  = 1'b1;
                    end else if (div_quo == '0) begin
                        n_state = S_DEGEN;
                    end else begin
                        n_n     = div_quo[IDX_W-1:0];
                        n_state = S_VMUL;
                        n_kick  = 1'b1;
                    end
                end
            end
            S_VMUL: begin
                mul_start = r_kick;
                mul_a     = MUL_AW'(r_mag[r_ax]);
                mul_b     = MUL_BW'(r_feed);
                if (mul_done) begin
                    n_num   = mul_prod[NUM_W-1:0];
                    n_state = S_VDIV;
                    n_kick  = 1'b1;
                end
            end
            S_VDIV: begin
                div_start = r_kick;
                div_dvd   = DVD_W'(r_num);
                div_dvs   = DVS_W'(r_len);
                if (div_done) begin
                    n_vel[r_ax] = vel_sat;
                    n_state     = S_PDIV;
                    n_kick      = 1'b1;
                end
            end
            S_PDIV: begin
                div_start = r_kick;
                div_dvd   = DVD_W'(r_mag[r_ax]);
                div_dvs   = DVS_W'(r_n);
                if (div_done) begin
                    n_qstep[r_ax] = div_quo[MAG_W-1:0];
                    n_rstep[r_ax] = div_rem[IDX_W-1:0];
                    if (r_ax == 2'd2) begin
                        n_state = S_EMIT;
                        n_k     = '0;
                        n_qacc  = '0;
                        n_racc  = '0;
                    end else begin
                        n_ax    = r_ax + 1'b1;
                        n_state = S_VMUL;
                        n_kick  = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_out_pos   = pos_now;
                n_out_vel   = r_vel;
                n_out_idx   = r_k;
                n_out_cap   = r_cap;
                n_out_last  = (r_k == r_n);
                for (int a = 0; a < 3; a++) begin
                    if (rsum[a] >= {1'b0, r_n}) begin
                        n_racc[a] = IDX_W'(rsum[a] - {1'b0, r_n});
                        n_qacc[a] = r_qacc[a] + r_qstep[a] + 1'b1;
                    end else begin
                        n_racc[a] = rsum[a][IDX_W-1:0];
                        n_qacc[a] = r_qacc[a] + r_qstep[a];
                    end
                end
                n_k = r_k + 1'b1;
                if (r_k == r_n) begin
                    n_state = S_IDLE;
                end
            end
            S_DEGEN: begin
                n_out_valid = 1'b1;
                n_out_pos   = r_t;
                n_out_vel   = '0;
                n_out_idx   = '0;
                n_out_cap   = 1'b0;
                n_out_last  = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RST;
        end else begin
            r_state     <= n_state;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s    <= in_s;
            r_t    <= in_t;
            r_feed <= i_feed_rate;
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= in_d[a][MAG_W-1];
                r_mag[a] <= in_d[a][MAG_W-1] ? -in_d[a] : in_d[a];
            end
        end
        r_ax       <= n_ax;
        r_sum      <= n_sum;
        r_len      <= n_len;
        r_den      <= n_den;
        r_num      <= n_num;
        r_n        <= n_n;
        r_cap      <= n_cap;
        r_vel      <= n_vel;
        r_qstep    <= n_qstep;
        r_rstep    <= n_rstep;
        r_qacc     <= n_qacc;
        r_racc     <= n_racc;
        r_k        <= n_k;
        r_out_pos  <= n_out_pos;
        r_out_vel  <= n_out_vel;
        r_out_idx  <= n_out_idx;
        r_out_cap  <= n_out_cap;
        r_out_last <= n_out_last;
    end

    assign o_strobe       = r_out_valid;
    assign o_pos_x        = r_out_pos[0];
    assign o_pos_y        = r_out_pos[1];
    assign o_pos_z        = r_out_pos[2];
    assign o_vel_x        = r_out_vel[0];
    assign o_vel_y        = r_out_vel[1];
    assign o_vel_z        = r_out_vel[2];
    assign o_point_index  = r_out_idx;
    assign o_steps_capped = r_out_cap;
    assign o_last_point   = r_out_last;

    `LMI_ASSERT_NXT(a_burst_gapless, i_clk, i_rst_n, r_out_valid && !r_out_last, r_out_valid, "gap inside point burst")
    `LMI_ASSERT_NXT(a_burst_ends, i_clk, i_rst_n, r_out_valid && r_out_last, !r_out_valid, "point after last point")
    `LMI_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_out_valid, r_out_idx <= MAX_N, "point index beyond maximum")

endmodule
